### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, cond, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### hw/rtl/sha_pkg.sv
// SHA-256 constants, command and status types.
// No dependencies.
package sha_pkg;
  typedef logic [31:0] word_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_AT = 6'd56;

  // byte source for a push
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_MARK = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  typedef struct packed {
    logic       push;       // write one byte into the block buffer
    logic [1:0] src;
    logic       count_bits; // add 8 to the message length
    logic       start;      // load working vars, begin rounds
    logic       round;      // run one round
    logic       fold;       // add working vars into chain
    logic       init;       // restart message
    logic       shift_out;  // rotate chain for digest output
  } cmd_t;

  typedef struct packed {
    logic [6:0] fill;
    logic [2:0] len_idx;
    logic       rounds_done;
  } stat_t;

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

### hw/rtl/sha_datapath.sv
// SHA-256 datapath: block buffer as 16-word schedule window, rounds, chain.
// Depends on sha_pkg.
module sha_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  sha_pkg::cmd_t  cmd,
  input  logic [7:0]     data_byte,
  output sha_pkg::stat_t stat,
  output logic [31:0]    digest_word
);
  sha_pkg::word_t w_r [16];
  sha_pkg::word_t v_r [8];
  sha_pkg::word_t h_r [8];
  logic [6:0]  fill_r;
  logic [63:0] bits_r, len_r;
  logic [2:0]  len_idx_r;
  logic [5:0]  rnd_r;
  logic [7:0]  byte_sel;
  sha_pkg::word_t s0, s1, w_new, se, ch, t1, sa, mj;

  always_comb begin
    case (cmd.src)
      sha_pkg::SRC_DATA: byte_sel = data_byte;
      sha_pkg::SRC_MARK: byte_sel = sha_pkg::PAD_MARK;
      sha_pkg::SRC_LEN:  byte_sel = len_r[63:56];
      default:           byte_sel = 8'd0;
    endcase
    s0 = sha_pkg::ror(w_r[1], 7) ^ sha_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha_pkg::ror(w_r[14], 17) ^ sha_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    se = sha_pkg::ror(v_r[4], 6) ^ sha_pkg::ror(v_r[4], 11) ^ sha_pkg::ror(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + se + ch + sha_pkg::K_TAB[rnd_r] + w_r[0];
    sa = sha_pkg::ror(v_r[0], 2) ^ sha_pkg::ror(v_r[0], 13) ^ sha_pkg::ror(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  assign stat.fill = fill_r;
  assign stat.len_idx = len_idx_r;
  assign stat.rounds_done = (rnd_r == 6'd63);
  assign digest_word = h_r[0];

  // window: bytes shift in at the low end of w_r[fill/4]; rounds shift words out at w_r[0]
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], byte_sel};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
    if (cmd.start) begin
      v_r <= h_r;
    end else if (cmd.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + sa + mj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      h_r <= sha_pkg::H_INIT;
      fill_r <= 7'd0;
      bits_r <= 64'd0;
      len_idx_r <= 3'd0;
      rnd_r <= 6'd0;
    end else begin
      if (cmd.count_bits) bits_r <= bits_r + 64'd8;
      if (cmd.push) begin
        fill_r <= fill_r + 7'd1;
        if (cmd.src == sha_pkg::SRC_MARK) len_r <= bits_r;
        if (cmd.src == sha_pkg::SRC_LEN) begin
          len_r <= {len_r[55:0], 8'd0};
          len_idx_r <= len_idx_r + 3'd1;
        end
      end
      if (cmd.start) begin
        fill_r <= 7'd0;
        rnd_r <= 6'd0;
      end
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
        h_r[7] <= h_r[0];
      end
    end
  end
endmodule

### hw/rtl/sha_ctrl.sv
// SHA-256 sequencer: accepts bytes, pads, runs rounds, emits digest.
// Depends on sha_pkg.
module sha_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           byte_valid,
  input  logic           message_end,
  input  logic           out_tready,
  output logic           out_tvalid,
  output logic [2:0]     word_idx,
  output sha_pkg::cmd_t  cmd,
  input  sha_pkg::stat_t stat
);
  localparam logic [2:0] S_IDLE = 3'd0, S_ROUND = 3'd1, S_FOLD = 3'd2,
                         S_PAD = 3'd3, S_OUT = 3'd4;
  logic [2:0] st_r, st_nxt;
  logic       pad_r, pad_nxt;       // message end pending
  logic       mark_r, mark_nxt;     // 0x80 already written
  logic       lenblk_r, lenblk_nxt; // length bytes belong in the current block
  logic       len_done_r;           // all eight length bytes written
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign in_tready = (st_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = (st_r == S_OUT);
  assign word_idx = idx_r;

  always_comb begin
    cmd = '0;
    st_nxt = st_r; pad_nxt = pad_r; mark_nxt = mark_r; idx_nxt = idx_r;
    lenblk_nxt = lenblk_r;
    case (st_r)
      S_IDLE: if (acc) begin
        if (byte_valid) begin
          cmd.push = 1'b1; cmd.src = sha_pkg::SRC_DATA; cmd.count_bits = 1'b1;
        end
        pad_nxt = message_end;
        mark_nxt = 1'b0;
        if (byte_valid && stat.fill == 7'd63) begin
          st_nxt = S_ROUND; cmd.start = 1'b1;
        end else if (message_end) st_nxt = S_PAD;
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (!mark_r) begin
          // mark past byte 55 leaves no room for the length in this block
          cmd.src = sha_pkg::SRC_MARK; mark_nxt = 1'b1;
          lenblk_nxt = (stat.fill[5:0] < sha_pkg::LEN_AT);
        end else if (lenblk_r && stat.fill[5:0] >= sha_pkg::LEN_AT) begin
          cmd.src = sha_pkg::SRC_LEN;
        end else cmd.src = sha_pkg::SRC_ZERO;
        if (stat.fill == 7'd63) begin
          cmd.start = 1'b1; st_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.rounds_done) st_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!pad_r) st_nxt = S_IDLE;
        else if (len_done_r) begin
          st_nxt = S_OUT; idx_nxt = 3'd0; // length bytes written: digest done
        end else begin
          st_nxt = S_PAD; lenblk_nxt = 1'b1;
        end
      end
      S_OUT: if (out_tready) begin
        cmd.shift_out = 1'b1;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          cmd.init = 1'b1; st_nxt = S_IDLE; pad_nxt = 1'b0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pad_r <= 1'b0; mark_r <= 1'b0; idx_r <= 3'd0;
      lenblk_r <= 1'b0; len_done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pad_r <= pad_nxt; mark_r <= mark_nxt; idx_r <= idx_nxt;
      lenblk_r <= lenblk_nxt;
      if (cmd.init || acc) len_done_r <= 1'b0;
      else if (cmd.push && cmd.src == sha_pkg::SRC_LEN && stat.len_idx == 3'd7)
        len_done_r <= 1'b1;
    end
  end
endmodule

### hw/rtl/sha256_message_hasher_core.sv
// SHA-256 message hasher core. A byte that fills a block starts 64 rounds,
// one per cycle, then the fold, and no input is taken until they are done.
// Message end adds padding at one byte a cycle, one or two blocks of rounds,
// then 8 digest requests. Input waits while padding, rounds or output run.
// Reset (rst_n, synchronous, low) loads initial hash, clears length and fill.
`include "assert_macros.svh"
module sha256_message_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // data_byte
  input  logic        in_tlast,  // message_end
  input  logic        in_tuser,  // byte_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // digest_word[31:0], word_index[34:32], zero fill
  output logic        out_tlast  // last_word
);
  sha_pkg::cmd_t  cmd;
  sha_pkg::stat_t stat;
  logic [31:0] dw;
  logic [2:0]  widx;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .byte_valid(in_tuser),
    .message_end(in_tlast), .out_tready, .out_tvalid, .word_idx(widx),
    .cmd, .stat);

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_tdata), .stat, .digest_word(dw));

  assign out_tdata = {5'd0, widx, dw};
  assign out_tlast = (widx == 3'd7);

  `ASSERT_IMPL(a_no_both, !(in_tready && out_tvalid), "input taken during output")
  `ASSERT_NEXT(a_last_idle, out_tvalid && out_tready && out_tlast, in_tready,
               "no return to idle after digest")
endmodule

### tb/sv/tb_sha256_message_hasher_core.sv
// Self-checking testbench for sha256_message_hasher_core: byte stream in,
// eight digest words out, checked against an in-bench SHA-256 predictor.
// Depends on sha_pkg and the core RTL.
module tb_sha256_message_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_req_t;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  always #1 clk = ~clk;

  sha256_message_hasher_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // predictor state
  sha_pkg::word_t hash_chain [8];
  logic [7:0]  blk_buf [64];
  int          blk_fill;
  logic [63:0] msg_bit_len;

  byte_req_t   pending_bytes [$];
  digest_req_t expected_words [$];
  int          fail_count = 0;
  int          src_idle_pct = 0;  // sender idle chance, percent
  int          snk_stall_pct = 0; // receiver stall chance, percent
  bit          hold_src = 1'b0;   // pause the sender while set
  bit          in_taken = 1'b0;   // request taken at the last rising edge
  int          quiet_cycles = 0;

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hash_chain[i] = sha_pkg::H_INIT[i];
    blk_fill = 0;
    msg_bit_len = '0;
  endtask

  task automatic compress_blk();
    sha_pkg::word_t w [64];
    sha_pkg::word_t v [8];
    sha_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K_TAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] += v[i];
  endtask

  task automatic blk_push(logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_blk();
      blk_fill = 0;
    end
  endtask

  // advance the predictor by one accepted request
  task automatic predict_digest(byte_req_t r);
    logic [63:0] total;
    digest_req_t d;
    if (r.byte_valid) begin
      msg_bit_len += 64'd8;
      blk_push(r.data_byte);
    end
    if (r.message_end) begin
      total = msg_bit_len;
      blk_push(sha_pkg::PAD_MARK);
      while (blk_fill != 56) blk_push(8'h00);
      for (int i = 0; i < 8; i++) blk_push(total[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_chain[i];
        d.word_index = 3'(i);
        d.last_word = (i == 7);
        expected_words.push_back(d);
      end
      hash_restart();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // driver: presents the head of the pending queue on the falling edge;
  // a request stays up unchanged until it has been taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // hold the request until taken
      end else if (pending_bytes.size() > 0 && !hold_src &&
                   $urandom_range(99) >= src_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_bytes[0].data_byte;
        in_tuser  <= pending_bytes[0].byte_valid;
        in_tlast  <= pending_bytes[0].message_end;
      end else begin
        in_tvalid <= 1'b0;
      end
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor: samples both handshakes at the rising edge
  always @(posedge clk) begin
    digest_req_t want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        predict_digest(pending_bytes.pop_front());
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_tdata[31:0], '0);
        end else begin
          want = expected_words.pop_front();
          if (out_tdata[31:0] !== want.digest_word)
            report_mismatch("digest_word", out_tdata[31:0], want.digest_word);
          if (out_tdata[34:32] !== want.word_index)
            report_mismatch("word_index", 32'(out_tdata[34:32]), 32'(want.word_index));
          if (out_tdata[39:35] !== 5'd0)
            report_mismatch("tdata fill", 32'(out_tdata[39:35]), 32'd0);
          if (out_tlast !== want.last_word)
            report_mismatch("last_word", 32'(out_tlast), 32'(want.last_word));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_req(logic [7:0] b, logic v, logic e);
    byte_req_t r;
    r.data_byte = b; r.byte_valid = v; r.message_end = e;
    pending_bytes.push_back(r);
  endtask

  // one message of random bytes, occasionally sprinkled with empty items
  task automatic add_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) add_req(8'($urandom), 1'b0, 1'b0);
      add_req(8'($urandom), 1'b1, (i == len - 1));
    end
    if (len == 0) add_req(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || expected_words.size() > 0) @(posedge clk);
  endtask

  initial begin
    int len;
    hash_restart();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty message, "abc", end mark on a byte, idle items,
    // extremes of the byte, and lengths around the padding boundary
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'h61, 1'b1, 1'b0);
    add_req(8'hff, 1'b0, 1'b0);
    add_req(8'h62, 1'b1, 1'b0);
    add_req(8'h63, 1'b1, 1'b1);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'h00, 1'b1, 1'b1);
    add_req(8'hff, 1'b0, 1'b1);
    wait_drained();
    // sender holds off while hold_src is set
    hold_src = 1'b1;
    repeat (20) @(posedge clk);
    hold_src = 1'b0;
    add_message(55);
    add_message(56);
    add_message(64);
    wait_drained();

    // random phases: free-running, sender idle, receiver stalling, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      for (int total = 0; total < 35; total += len + 1) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
        add_message(len);
      end
      wait_drained();
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha_datapath.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha256_message_hasher_core.sv
tb/sv/tb_sha256_message_hasher_core.sv
